[design/gvd_pkg.sv]
// Shared types and constants for the gesture vote debounce block.
package gvd_pkg;

    // Vote window length and derived widths
    localparam int WINDOW_LEN = 10;
    localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
    localparam int NUM_CODES  = 4;

    // Queue between front and back
    localparam int MID_DEPTH  = 4;
    localparam int MID_PTR_W  = $clog2(MID_DEPTH);
    localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);

    // Field widths
    localparam int POS_W   = 13;
    localparam int DIM_W   = 12;
    localparam int HEAD_W  = 14;
    localparam int SQ_W    = 2 * HEAD_W - 1;
    localparam int DIST_W  = 28;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    // Register map, by word index
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MIN_DIST_SQ  = 2'd2;
    localparam logic [1:0] REG_MAX_DIST_SQ  = 2'd3;

    // Reset values of the registers
    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [DIST_W-1:0] RST_MIN_DIST_SQ  = 28'd1000000;
    localparam logic [DIST_W-1:0] RST_MAX_DIST_SQ  = 28'd2890000;

    // Frame class codes
    typedef enum logic [1:0] {
        CODE_NONE   = 2'd0,
        CODE_FIST   = 2'd1,
        CODE_PALM   = 2'd2,
        CODE_URGENT = 2'd3
    } t_code;

    // Configuration seen by the front end
    typedef struct packed {
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [DIST_W-1:0] min_dist_sq;
        logic [DIST_W-1:0] max_dist_sq;
    } t_cfg;

endpackage

[design/gvd_front.sv]
// Front end: takes frames, squares head offsets and classifies each frame.
module gvd_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gvd_pkg::t_cfg                    i_cfg,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic signed [gvd_pkg::POS_W-1:0]  i_hand_x,
    input  logic signed [gvd_pkg::POS_W-1:0]  i_hand_y,
    input  logic                             i_fist_found,
    input  logic                             i_palm_found,
    input  logic signed [gvd_pkg::HEAD_W-1:0] i_head_dx,
    input  logic signed [gvd_pkg::HEAD_W-1:0] i_head_dy,
    input  logic signed [gvd_pkg::HEAD_W-1:0] i_head_dz,
    output logic                             o_code_push,
    output gvd_pkg::t_code                   o_code,
    input  logic                             i_code_full
);

    logic                           r_valid;
    logic                           r_outside;
    logic                           r_fist;
    logic                           r_palm;
    logic [gvd_pkg::SQ_W-1:0]       r_sq_x;
    logic [gvd_pkg::SQ_W-1:0]       r_sq_y;
    logic [gvd_pkg::SQ_W-1:0]       r_sq_z;

    logic                           accept;
    logic                           outside;
    logic [gvd_pkg::HEAD_W-1:0]     abs_x;
    logic [gvd_pkg::HEAD_W-1:0]     abs_y;
    logic [gvd_pkg::HEAD_W-1:0]     abs_z;
    logic [gvd_pkg::DIST_W-1:0]     dist_sq;
    logic                           urgent;

    // Stage holds while its beat cannot enter the queue
    assign o_full      = r_valid && i_code_full;
    assign accept      = i_push && !o_full;
    assign o_code_push = r_valid && !i_code_full;

    // Hand position against the image bounds
    assign outside = i_hand_x[gvd_pkg::POS_W-1]
                  || (i_hand_x[gvd_pkg::DIM_W-1:0] > i_cfg.image_width)
                  || i_hand_y[gvd_pkg::POS_W-1]
                  || (i_hand_y[gvd_pkg::DIM_W-1:0] > i_cfg.image_height);

    // Magnitudes of the head offsets
    assign abs_x = i_head_dx[gvd_pkg::HEAD_W-1] ? 14'(-i_head_dx) : 14'(i_head_dx);
    assign abs_y = i_head_dy[gvd_pkg::HEAD_W-1] ? 14'(-i_head_dy) : 14'(i_head_dy);
    assign abs_z = i_head_dz[gvd_pkg::HEAD_W-1] ? 14'(-i_head_dz) : 14'(i_head_dz);

    // Register validity of the square stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_code_push) begin
            r_valid <= 1'b0;
        end
    end

    // Capture squares and flags
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_outside <= outside;
            r_fist    <= i_fist_found;
            r_palm    <= i_palm_found;
            r_sq_x    <= gvd_pkg::SQ_W'(abs_x) * gvd_pkg::SQ_W'(abs_x);
            r_sq_y    <= gvd_pkg::SQ_W'(abs_y) * gvd_pkg::SQ_W'(abs_y);
            r_sq_z    <= gvd_pkg::SQ_W'(abs_z) * gvd_pkg::SQ_W'(abs_z);
        end
    end

    // Sum the squares and classify
    assign dist_sq = gvd_pkg::DIST_W'(r_sq_x) + gvd_pkg::DIST_W'(r_sq_y)
                   + gvd_pkg::DIST_W'(r_sq_z);
    assign urgent  = (dist_sq < i_cfg.min_dist_sq) || (dist_sq > i_cfg.max_dist_sq);

    always_comb begin
        if (r_outside) begin
            o_code = gvd_pkg::CODE_NONE;
        end else if (urgent) begin
            o_code = gvd_pkg::CODE_URGENT;
        end else if (r_fist && !r_palm) begin
            o_code = gvd_pkg::CODE_FIST;
        end else if (!r_fist && r_palm) begin
            o_code = gvd_pkg::CODE_PALM;
        end else begin
            o_code = gvd_pkg::CODE_NONE;
        end
    end

endmodule

[design/gvd_fifo.sv]
// Short queue of frame codes between the front end and the vote stage.
module gvd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gvd_pkg::t_code i_data,
    output logic           o_full,
    input  logic           i_pop,
    output gvd_pkg::t_code o_data,
    output logic           o_empty
);

    gvd_pkg::t_code                  r_mem [gvd_pkg::MID_DEPTH];
    logic [gvd_pkg::MID_PTR_W-1:0]   r_wr_ptr;
    logic [gvd_pkg::MID_PTR_W-1:0]   r_rd_ptr;
    logic [gvd_pkg::MID_CNT_W-1:0]   r_count;

    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_count == gvd_pkg::MID_CNT_W'(gvd_pkg::MID_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/gvd_back.sv]
// Back end: sliding-window majority vote, change detection and result register.
module gvd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_code_empty,
    input  gvd_pkg::t_code                    i_code,
    output logic                              o_code_pop,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic [1:0]                        o_event_code,
    output logic [1:0]                        o_smoothed_code,
    output logic [1:0]                        o_raw_code
);

    gvd_pkg::t_code              r_window [gvd_pkg::WINDOW_LEN];
    logic [gvd_pkg::CNT_W-1:0]   r_fill;
    logic [gvd_pkg::CNT_W-1:0]   r_cnt [gvd_pkg::NUM_CODES];
    gvd_pkg::t_code              r_prev;
    logic                        r_have_prev;
    logic                        r_out_valid;
    gvd_pkg::t_code              r_event;
    gvd_pkg::t_code              r_smooth;
    gvd_pkg::t_code              r_raw;

    logic                        step;
    logic                        full_window;
    gvd_pkg::t_code              oldest;
    logic [gvd_pkg::CNT_W-1:0]   n_cnt [gvd_pkg::NUM_CODES];
    logic [gvd_pkg::CNT_W-1:0]   best;
    gvd_pkg::t_code              smooth;
    gvd_pkg::t_code              evt;

    // Take a code whenever the result register is free or being drained
    assign step        = !i_code_empty && (!r_out_valid || i_pop);
    assign o_code_pop  = step;
    assign full_window = (r_fill == gvd_pkg::CNT_W'(gvd_pkg::WINDOW_LEN));
    assign oldest      = r_window[gvd_pkg::WINDOW_LEN-1];

    // Running counts: add the new code, drop the one that leaves the window
    always_comb begin
        for (int c = 0; c < gvd_pkg::NUM_CODES; c++) begin
            n_cnt[c] = r_cnt[c]
                     + gvd_pkg::CNT_W'(i_code == gvd_pkg::t_code'(2'(c)))
                     - gvd_pkg::CNT_W'(full_window && (oldest == gvd_pkg::t_code'(2'(c))));
        end
    end

    // Majority: strict compare keeps the lower code on a tie
    always_comb begin
        best   = '0;
        smooth = gvd_pkg::CODE_NONE;
        for (int c = 0; c < gvd_pkg::NUM_CODES; c++) begin
            if (n_cnt[c] > best) begin
                best   = n_cnt[c];
                smooth = gvd_pkg::t_code'(2'(c));
            end
        end
    end

    assign evt = (r_have_prev && (smooth != r_prev)) ? smooth : gvd_pkg::CODE_NONE;

    // Window, counts and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < gvd_pkg::WINDOW_LEN; k++) begin
                r_window[k] <= gvd_pkg::CODE_NONE;
            end
            for (int c = 0; c < gvd_pkg::NUM_CODES; c++) begin
                r_cnt[c] <= '0;
            end
            r_fill      <= '0;
            r_prev      <= gvd_pkg::CODE_NONE;
            r_have_prev <= 1'b0;
        end else if (step) begin
            r_window[0] <= i_code;
            for (int k = 1; k < gvd_pkg::WINDOW_LEN; k++) begin
                r_window[k] <= r_window[k-1];
            end
            for (int c = 0; c < gvd_pkg::NUM_CODES; c++) begin
                r_cnt[c] <= n_cnt[c];
            end
            if (!full_window) begin
                r_fill <= r_fill + 1'b1;
            end
            r_prev      <= smooth;
            r_have_prev <= 1'b1;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event  <= evt;
            r_smooth <= smooth;
            r_raw    <= i_code;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_event_code    = r_event;
    assign o_smoothed_code = r_smooth;
    assign o_raw_code      = r_raw;

endmodule

[design/gesture_vote_debounce.sv]
// Top level of the gesture vote debounce block: register file, front, queue and vote.
//
// Each frame beat is classified as none, fist, palm or urgency and voted over the last
// ten frames (fewer just after reset); one result beat comes out per frame beat, in order.
// A beat can be taken on every clock cycle while full is low. A result beat passes through
// the squaring register of the front end and the four-entry code queue; it then waits in
// the result register of the vote stage until it is popped. Back-pressure on pop fills the
// queue and then raises full. Registers sit at byte addresses 0 (image width), 4 (image
// height), 8 (minimum squared distance) and 12 (maximum squared distance); the user must
// write them only while no frame is in flight, as the block itself does not enforce this.
module gesture_vote_debounce (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gvd_pkg::ADDR_W-1:0]        paddr,
    input  logic [gvd_pkg::DATA_W-1:0]        pwdata,
    output logic [gvd_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic signed [gvd_pkg::POS_W-1:0]  i_hand_x,
    input  logic signed [gvd_pkg::POS_W-1:0]  i_hand_y,
    input  logic                              i_fist_found,
    input  logic                              i_palm_found,
    input  logic signed [gvd_pkg::HEAD_W-1:0] i_head_dx,
    input  logic signed [gvd_pkg::HEAD_W-1:0] i_head_dy,
    input  logic signed [gvd_pkg::HEAD_W-1:0] i_head_dz,
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        o_event_code,
    output logic [1:0]                        o_smoothed_code,
    output logic [1:0]                        o_raw_code
);

    gvd_pkg::t_cfg   r_cfg;
    logic            cfg_write;
    logic [1:0]      reg_idx;
    logic            code_push;
    gvd_pkg::t_code  code_in;
    logic            code_full;
    logic            code_pop;
    gvd_pkg::t_code  code_out;
    logic            code_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[3:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= gvd_pkg::RST_IMAGE_WIDTH;
            r_cfg.image_height <= gvd_pkg::RST_IMAGE_HEIGHT;
            r_cfg.min_dist_sq  <= gvd_pkg::RST_MIN_DIST_SQ;
            r_cfg.max_dist_sq  <= gvd_pkg::RST_MAX_DIST_SQ;
        end else if (cfg_write) begin
            case (reg_idx)
                gvd_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= pwdata[gvd_pkg::DIM_W-1:0];
                end
                gvd_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= pwdata[gvd_pkg::DIM_W-1:0];
                end
                gvd_pkg::REG_MIN_DIST_SQ: begin
                    r_cfg.min_dist_sq <= pwdata[gvd_pkg::DIST_W-1:0];
                end
                gvd_pkg::REG_MAX_DIST_SQ: begin
                    r_cfg.max_dist_sq <= pwdata[gvd_pkg::DIST_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            gvd_pkg::REG_IMAGE_WIDTH:  prdata = gvd_pkg::DATA_W'(r_cfg.image_width);
            gvd_pkg::REG_IMAGE_HEIGHT: prdata = gvd_pkg::DATA_W'(r_cfg.image_height);
            gvd_pkg::REG_MIN_DIST_SQ:  prdata = gvd_pkg::DATA_W'(r_cfg.min_dist_sq);
            gvd_pkg::REG_MAX_DIST_SQ:  prdata = gvd_pkg::DATA_W'(r_cfg.max_dist_sq);
            default:                   prdata = '0;
        endcase
    end

    gvd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_push       (push),
        .o_full       (full),
        .i_hand_x     (i_hand_x),
        .i_hand_y     (i_hand_y),
        .i_fist_found (i_fist_found),
        .i_palm_found (i_palm_found),
        .i_head_dx    (i_head_dx),
        .i_head_dy    (i_head_dy),
        .i_head_dz    (i_head_dz),
        .o_code_push  (code_push),
        .o_code       (code_in),
        .i_code_full  (code_full)
    );

    gvd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (code_push),
        .i_data  (code_in),
        .o_full  (code_full),
        .i_pop   (code_pop),
        .o_data  (code_out),
        .o_empty (code_empty)
    );

    gvd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_code_empty    (code_empty),
        .i_code          (code_out),
        .o_code_pop      (code_pop),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_event_code    (o_event_code),
        .o_smoothed_code (o_smoothed_code),
        .o_raw_code      (o_raw_code)
    );

endmodule
